>>> design/ctcb_pkg.sv
// Trace capture buffer package: shared constants, kind codes and beat structs.
// No dependencies.
`default_nettype none

package ctcb_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned SIZE_RESET = 16;
  localparam int unsigned SIZE_MIN   = 3;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned OFFS_W     = 4;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_FETCH  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // one stored trace record
  typedef struct packed {
    logic [31:0] tag;
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic [63:0] thread;
  } entry_t;

  // per-beat control travelling alongside a store read
  typedef struct packed {
    logic vld;
    logic last;
    logic empty;
    logic lost;
  } meta_t;

  // one result beat
  typedef struct packed {
    entry_t ent;
    logic   lost;
    logic   empty;
    logic   last;
  } res_t;

endpackage

`default_nettype wire

>>> design/ctcb_mem.sv
// Record store: one write port, one read port, registered read data.
// Depends on ctcb_pkg.
`default_nettype none

module ctcb_mem
  import ctcb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/ctcb_seq.sv
// Ring control: write pointer, wrap flag, size register and fetch read sequencer.
// Depends on ctcb_pkg.
`default_nettype none

module ctcb_seq
  import ctcb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned PW   = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [OFFS_W-1:0] start_offset_i,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              can_issue_i,
  output      logic              we_o,
  output      logic [AW-1:0]     waddr_o,
  output      logic              re_o,
  output      logic [AW-1:0]     raddr_o,
  output      meta_t             iss_o
);

  localparam int unsigned CW = ((PW > OFFS_W) ? PW : OFFS_W) + 1;
  localparam int unsigned VW = (PW > CFG_W) ? PW : CFG_W;
  localparam int unsigned SIZE_RST = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

  logic          busy_q, busy_d;
  logic          empty_q, empty_d;
  logic          wrapped_q, wrapped_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] size_q, size_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [PW-1:0] rem_q, rem_d;

  logic          in_acc;
  logic          wrap_rec;
  logic          issue;
  logic [PW-1:0] count;
  logic [CW-1:0] count_x, start_x, size_x, pos0, pos0_w;
  logic [PW-1:0] pos_inc;
  logic [VW-1:0] cfg_x;
  logic [VW-1:0] clamp_v;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = !busy_q;
  assign in_acc      = in_valid_i && !busy_q;
  assign issue       = busy_q && can_issue_i;

  // lazy wrap: the record after the one that filled the ring goes to entry 0
  assign wrap_rec = (wp_q >= size_q);
  assign we_o     = in_acc && (kind_e'(kind_i) == KIND_RECORD);
  assign waddr_o  = wrap_rec ? '0 : AW'(wp_q);

  assign count   = wrapped_q ? size_q : wp_q;
  assign count_x = CW'(count);
  assign start_x = CW'(start_offset_i);
  assign size_x  = CW'(size_q);
  assign pos0    = (wrapped_q ? CW'(wp_q) : '0) + start_x;
  assign pos0_w  = (pos0 >= size_x) ? (pos0 - size_x) : pos0;
  assign pos_inc = PW'(pos_q) + PW'(1);

  assign cfg_x = VW'(cfg_data_i);
  always_comb begin
    if (cfg_x < VW'(SIZE_MIN)) begin
      clamp_v = VW'(SIZE_MIN);
    end else if (cfg_x > VW'(DEPTH)) begin
      clamp_v = VW'(DEPTH);
    end else begin
      clamp_v = cfg_x;
    end
  end

  assign re_o       = issue && !empty_q;
  assign raddr_o    = pos_q;
  assign iss_o.vld   = issue;
  assign iss_o.last  = empty_q || (rem_q == PW'(1));
  assign iss_o.empty = empty_q;
  assign iss_o.lost  = wrapped_q;

  always_comb begin
    busy_d    = busy_q;
    empty_d   = empty_q;
    wrapped_d = wrapped_q;
    wp_d      = wp_q;
    size_d    = size_q;
    pos_d     = pos_q;
    rem_d     = rem_q;

    if (in_acc) begin
      unique case (kind_e'(kind_i))
        KIND_RECORD: begin
          wp_d = wrap_rec ? PW'(1) : (wp_q + PW'(1));
          if (wrap_rec) begin
            wrapped_d = 1'b1;
          end
        end
        KIND_FETCH: begin
          busy_d  = 1'b1;
          empty_d = (start_x >= count_x);
          pos_d   = AW'(pos0_w);
          rem_d   = PW'(count_x - start_x);
        end
        KIND_CLEAR: begin
          wp_d      = '0;
          wrapped_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (issue) begin
      if (empty_q || (rem_q == PW'(1))) begin
        busy_d = 1'b0;
      end
      pos_d = (pos_inc == size_q) ? '0 : AW'(pos_inc);
      rem_d = rem_q - PW'(1);
    end

    if (cfg_valid_i && !busy_q) begin
      size_d    = PW'(clamp_v);
      wp_d      = '0;
      wrapped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      empty_q   <= 1'b0;
      wrapped_q <= 1'b0;
      wp_q      <= '0;
      size_q    <= PW'(SIZE_RST);
    end else begin
      busy_q    <= busy_d;
      empty_q   <= empty_d;
      wrapped_q <= wrapped_d;
      wp_q      <= wp_d;
      size_q    <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    rem_q <= rem_d;
  end

endmodule

`default_nettype wire

>>> design/ctcb_outq.sv
// Result path: read-data alignment stage and a two-beat output queue.
// Depends on ctcb_pkg.
`default_nettype none

module ctcb_outq
  import ctcb_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire meta_t  iss_i,
  input  wire entry_t rdata_i,
  input  wire logic   pop_i,
  output      logic   can_issue_o,
  output      logic   valid_o,
  output      res_t   res_o
);

  logic       infl_q;
  meta_t      meta_q;
  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  res_t       push_res;
  logic [2:0] occ;

  assign push = infl_q;

  always_comb begin
    push_res.ent   = meta_q.empty ? '0 : rdata_i;
    push_res.lost  = meta_q.lost;
    push_res.empty = meta_q.empty;
    push_res.last  = meta_q.last;
  end

  // a read issued now lands in the next cycle; keep queue plus in-flight within two
  assign occ         = {1'b0, cnt_q} + {2'b00, infl_q} - {2'b00, pop_i};
  assign can_issue_o = (occ < 3'd2);

  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      infl_q <= iss_i.vld;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= iss_i;
    if (push) begin
      slot_q[wr_ptr_q] <= push_res;
    end
  end

endmodule

`default_nettype wire

>>> design/circular_trace_capture_buffer.sv
// Circular trace capture buffer, top level. Uses ctcb_pkg, ctcb_seq, ctcb_mem, ctcb_outq.
// A record beat is stored in the cycle it is taken, one every cycle while no fetch runs.
// A fetch beat is taken in one handshake; its first result passes the busy flag, read
// register and queue slot, then one result per cycle while the sink is ready, paced by
// the single store read port. No input beat is taken while a fetch is issuing reads.
// Reset (rst_ni, async, low): pointer and wrap flag cleared, size back to its default;
// the store is not cleared and needs no clearing pass.
`default_nettype none

module circular_trace_capture_buffer
  import ctcb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item channel
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [31:0]       site_tag_i,
  input  wire logic [63:0]       value_a_i,
  input  wire logic [63:0]       value_b_i,
  input  wire logic [63:0]       thread_id_i,
  input  wire logic [OFFS_W-1:0] start_offset_i,
  // size register write channel
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  // result channel
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [31:0]       out_tag_o,
  output      logic [63:0]       out_value_a_o,
  output      logic [63:0]       out_value_b_o,
  output      logic [63:0]       out_thread_o,
  output      logic              lost_older_o,
  output      logic              is_empty_o,
  output      logic              last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          we, re, can_issue, pop;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  meta_t         iss;
  res_t          res;

  // record payload as stored
  always_comb begin
    wdata.tag     = site_tag_i;
    wdata.value_a = value_a_i;
    wdata.value_b = value_b_i;
    wdata.thread  = thread_id_i;
  end

  // Control: decodes the item, keeps write pointer / wrap flag / size, and
  // walks the ring oldest first on a fetch, one read per cycle when the
  // result queue has room.
  ctcb_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .start_offset_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .can_issue_i (can_issue),
    .we_o        (we),
    .waddr_o     (waddr),
    .re_o        (re),
    .raddr_o     (raddr),
    .iss_o       (iss)
  );

  // Record store, one entry per ring slot.
  ctcb_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read data meets its beat flags here; a two-deep queue decouples the
  // sink so a stalled result never loses an in-flight read.
  assign pop = out_valid_o && out_ready_i;

  ctcb_outq u_outq (
    .clk_i,
    .rst_ni,
    .iss_i       (iss),
    .rdata_i     (rdata),
    .pop_i       (pop),
    .can_issue_o (can_issue),
    .valid_o     (out_valid_o),
    .res_o       (res)
  );

  assign out_tag_o     = res.ent.tag;
  assign out_value_a_o = res.ent.value_a;
  assign out_value_b_o = res.ent.value_b;
  assign out_thread_o  = res.ent.thread;
  assign lost_older_o  = res.lost;
  assign is_empty_o    = res.empty;
  assign last_o        = res.last;

endmodule

`default_nettype wire

>>> design/ctcb_checker.sv
// Port-level checks for the trace capture buffer, bound to the top level.
// Depends on ctcb_pkg and circular_trace_capture_buffer.
`default_nettype none

module ctcb_checker
  import ctcb_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        kind_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [31:0]       out_tag_o,
  input wire logic [63:0]       out_value_a_o,
  input wire logic [63:0]       out_value_b_o,
  input wire logic [63:0]       out_thread_o,
  input wire logic              lost_older_o,
  input wire logic              is_empty_o,
  input wire logic              last_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_tag_o) && $stable(last_o)
      && $stable(is_empty_o) && $stable(out_thread_o) && $stable(out_value_a_o)
      && $stable(out_value_b_o) && $stable(lost_older_o))
    else $error("result beat changed while stalled");

  // an empty result is always the final one of its fetch
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> last_o)
    else $error("empty result not marked last");

  // an empty result carries zero entry fields
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (out_tag_o == '0) && (out_value_a_o == '0)
      && (out_value_b_o == '0) && (out_thread_o == '0))
    else $error("empty result with non-zero entry fields");

  // a fetch holds off the next item while its reads are issued
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_FETCH) |=> !in_ready_o)
    else $error("item taken during fetch");

endmodule

bind circular_trace_capture_buffer ctcb_checker u_ctcb_checker (.*);

`default_nettype wire
